@@ design/pl1dm_pkg.sv @@
// Shared constants for the pairwise L1 distance matrix unit.
// No dependencies; used by the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pl1dm_pkg;

	localparam int DATA_W       = 16;
	localparam int ROW_OUT_W    = 6;
	localparam int DIST_W       = 26;
	localparam int ROWS_CFG_W   = 7;
	localparam int COLS_CFG_W   = 11;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 1024;

	localparam logic [DIST_W-1:0]     DIST_MAX    = {DIST_W{1'b1}};
	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET  = 7'd64;
	localparam logic [COLS_CFG_W-1:0] COLS_RESET  = 11'd1024;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

endpackage
`default_nettype wire

@@ design/pl1dm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pl1dm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/pl1dm_cell.sv @@
// One cell of the distance chain: holds one stored row and its running sum.
// Depends on pl1dm_pkg and pl1dm_ram.
`timescale 1ns / 1ps
`default_nettype none
module pl1dm_cell #(
	parameter int INDEX = 0,
	parameter int ROW_W = 6,
	parameter int COL_W = 10,
	parameter int SUM_W = 26,
	parameter int DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [ROW_W-1:0]             in_row,
	input  wire logic [COL_W-1:0]             in_col,
	input  wire logic [pl1dm_pkg::DATA_W-1:0] in_value,
	output logic                              out_valid,
	output logic      [ROW_W-1:0]             out_row,
	output logic      [COL_W-1:0]             out_col,
	output logic      [pl1dm_pkg::DATA_W-1:0] out_value,
	input  wire logic                         shift,
	input  wire logic [SUM_W-1:0]             sum_in,
	output logic      [SUM_W-1:0]             sum
);

	localparam int DW = pl1dm_pkg::DATA_W;

	logic          [DW-1:0] rdata;
	logic signed   [DW:0]   diff;
	logic          [DW:0]   mag;
	logic          [DW-1:0] absd;
	logic                   active;
	logic                   own_write;
	logic          [SUM_W-1:0] sum_q;

	assign own_write = in_valid && (in_row == ROW_W'(INDEX));

	pl1dm_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_row_ram (
		.clk  (clk),
		.we   (own_write),
		.waddr(in_col),
		.wdata(in_value),
		.raddr(in_col),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_row   <= in_row;
		out_col   <= in_col;
		out_value <= in_value;
	end

	assign diff   = $signed({rdata[DW-1], rdata}) - $signed({out_value[DW-1], out_value});
	assign mag    = diff[DW] ? (~diff + 1'b1) : diff;
	assign absd   = mag[DW-1:0];
	assign active = out_row > ROW_W'(INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= sum_in;
		end else if (out_valid) begin
			if (out_col == '0) begin
				sum_q <= active ? SUM_W'(absd) : '0;
			end else if (active) begin
				sum_q <= sum_q + SUM_W'(absd);
			end
		end
	end

	assign sum = sum_q;

endmodule
`default_nettype wire

@@ design/pairwise_l1_distance_matrix_unit.sv @@
// Top level of the pairwise L1 distance matrix unit: control, register port,
// output register and the chain of cells. Depends on pl1dm_pkg and pl1dm_cell.
//
//   Channel  Direction  Width  Contents
//   s_*      in         16     one matrix element, row-major
//   m_*      out        40     one distance pair, tlast on the final pair
//   APB      in/out     32     rows_in_use at 0x0, cols_in_use at 0x4
//
// Elements are accepted only in the run state. After the last element of row
// j the input pauses while that word travels the whole cell chain, then the
// j+1 sums are shifted out of cell 0, one per cycle that the output register
// is free. Reset clears control and presets the register port; row memories
// are not cleared. A stalled m_tready holds the result and pauses the shift.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_l1_distance_matrix_unit #(
	parameter int MAX_ROWS = pl1dm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = pl1dm_pkg::DEF_MAX_COLS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // value[15:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // row_a[5:0], row_b[11:6], distance[37:12], zero
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [pl1dm_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pl1dm_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [pl1dm_pkg::APB_DATA_W-1:0] prdata,
	output logic             pready
);

	localparam int DW     = pl1dm_pkg::DATA_W;
	localparam int DIST_W = pl1dm_pkg::DIST_W;
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SUM_W  = DW + COL_W;
	localparam int EXT_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;
	localparam int WAIT_W = $clog2(MAX_ROWS + 2);
	localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(MAX_ROWS + 1);

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_WAIT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	logic [pl1dm_pkg::ROWS_CFG_W-1:0] rows_q;
	logic [pl1dm_pkg::COLS_CFG_W-1:0] cols_q;
	logic cfg_write;

	logic [31:0] nr;
	logic [31:0] nc;
	logic [ROW_W-1:0] row_pos_q;
	logic [COL_W-1:0] col_pos_q;
	logic accept, end_row, end_matrix;

	logic [ROW_W-1:0]  drain_row_q;
	logic [ROW_W-1:0]  idx_q;
	logic              drain_last_q;
	logic [WAIT_W-1:0] wait_q;

	logic              tok_valid_s1;
	logic [ROW_W-1:0]  tok_row_s1;
	logic [COL_W-1:0]  tok_col_s1;
	logic [DW-1:0]     tok_value_s1;

	logic              c_valid [0:MAX_ROWS-1];
	logic [ROW_W-1:0]  c_row   [0:MAX_ROWS-1];
	logic [COL_W-1:0]  c_col   [0:MAX_ROWS-1];
	logic [DW-1:0]     c_value [0:MAX_ROWS-1];
	logic [SUM_W-1:0]  c_sum   [0:MAX_ROWS-1];

	logic              shift, out_free;
	logic [EXT_W-1:0]  sum_ext;
	logic [DIST_W-1:0] dist_sat;

	logic                               m_tvalid_q;
	logic                               m_tlast_q;
	logic [pl1dm_pkg::ROW_OUT_W-1:0]    row_a_q;
	logic [pl1dm_pkg::ROW_OUT_W-1:0]    row_b_q;
	logic [DIST_W-1:0]                  dist_q;

	// Register port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == pl1dm_pkg::REG_COLS) ? 32'(cols_q) : 32'(rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= pl1dm_pkg::ROWS_RESET;
			cols_q <= pl1dm_pkg::COLS_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				pl1dm_pkg::REG_ROWS: rows_q <= pwdata[pl1dm_pkg::ROWS_CFG_W-1:0];
				pl1dm_pkg::REG_COLS: cols_q <= pwdata[pl1dm_pkg::COLS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == '0) begin
			nr = 32'd1;
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			nr = 32'(MAX_ROWS);
		end else begin
			nr = 32'(rows_q);
		end
		if (cols_q == '0) begin
			nc = 32'd1;
		end else if (32'(cols_q) > 32'(MAX_COLS)) begin
			nc = 32'(MAX_COLS);
		end else begin
			nc = 32'(cols_q);
		end
	end

	assign s_tready   = (state_q == ST_RUN);
	assign accept     = s_tvalid && s_tready;
	assign end_row    = (32'(col_pos_q) + 32'd1) >= nc;
	assign end_matrix = (32'(row_pos_q) + 32'd1) >= nr;

	assign out_free = !m_tvalid_q || m_tready;
	assign shift    = (state_q == ST_DRAIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			row_pos_q    <= '0;
			col_pos_q    <= '0;
			idx_q        <= '0;
			wait_q       <= '0;
			drain_row_q  <= '0;
			drain_last_q <= 1'b0;
			tok_valid_s1 <= 1'b0;
		end else begin
			tok_valid_s1 <= accept;
			case (state_q)
				ST_RUN: begin
					if (accept) begin
						if (end_row) begin
							col_pos_q    <= '0;
							row_pos_q    <= end_matrix ? '0 : row_pos_q + 1'b1;
							drain_row_q  <= row_pos_q;
							drain_last_q <= end_matrix;
							wait_q       <= '0;
							idx_q        <= '0;
							state_q      <= ST_WAIT;
						end else begin
							col_pos_q <= col_pos_q + 1'b1;
						end
					end
				end
				ST_WAIT: begin
					if (wait_q == WAIT_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						wait_q <= wait_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						if (idx_q == drain_row_q) begin
							state_q <= ST_RUN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tok_row_s1   <= row_pos_q;
		tok_col_s1   <= col_pos_q;
		tok_value_s1 <= s_tdata;
	end

	// Cell chain: the element word moves one cell per cycle, sums shift back.
	assign c_valid[0] = tok_valid_s1;
	assign c_row[0]   = tok_row_s1;
	assign c_col[0]   = tok_col_s1;
	assign c_value[0] = tok_value_s1;

	for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
		if (k < MAX_ROWS - 1) begin : g_mid
			pl1dm_cell #(
				.INDEX(k), .ROW_W(ROW_W), .COL_W(COL_W), .SUM_W(SUM_W), .DEPTH(MAX_COLS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (c_valid[k]),
				.in_row   (c_row[k]),
				.in_col   (c_col[k]),
				.in_value (c_value[k]),
				.out_valid(c_valid[k+1]),
				.out_row  (c_row[k+1]),
				.out_col  (c_col[k+1]),
				.out_value(c_value[k+1]),
				.shift    (shift),
				.sum_in   (c_sum[k+1]),
				.sum      (c_sum[k])
			);
		end else begin : g_end
			pl1dm_cell #(
				.INDEX(k), .ROW_W(ROW_W), .COL_W(COL_W), .SUM_W(SUM_W), .DEPTH(MAX_COLS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (c_valid[k]),
				.in_row   (c_row[k]),
				.in_col   (c_col[k]),
				.in_value (c_value[k]),
				.out_valid(),
				.out_row  (),
				.out_col  (),
				.out_value(),
				.shift    (shift),
				.sum_in   ({SUM_W{1'b0}}),
				.sum      (c_sum[k])
			);
		end
	end

	// Output register.
	assign sum_ext  = EXT_W'(c_sum[0]);
	assign dist_sat = (sum_ext > EXT_W'(pl1dm_pkg::DIST_MAX)) ?
		pl1dm_pkg::DIST_MAX : DIST_W'(sum_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (shift) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			row_a_q   <= pl1dm_pkg::ROW_OUT_W'(idx_q);
			row_b_q   <= pl1dm_pkg::ROW_OUT_W'(drain_row_q);
			dist_q    <= (idx_q == drain_row_q) ? '0 : dist_sat;
			m_tlast_q <= drain_last_q && (idx_q == drain_row_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {2'b00, dist_q, row_b_q, row_a_q};

endmodule
`default_nettype wire
